@@ hw/rtl/cartridge_bank_mapper_unit_defines.svh @@
// Assertion macros shared by the cartridge bank mapper RTL.
// Each macro takes a label, the clock, the active-low reset and the checked terms.
`ifndef CARTRIDGE_BANK_MAPPER_UNIT_DEFINES_SVH
`define CARTRIDGE_BANK_MAPPER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define CBM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("cartridge bank mapper check failed");

// Next-cycle implication, disabled while reset is low.
`define CBM_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("cartridge bank mapper check failed");

`endif

@@ hw/rtl/cbm_pkg.sv @@
// Shared constants for the cartridge bank mapper: result codes, register indexes,
// sequencer state codes and reset values. No dependencies.
package cbm_pkg;

  localparam int unsigned MaxRomBanksDef = 512;
  localparam int unsigned MaxRamBanksDef = 16;

  // Result target codes
  localparam logic [2:0] T_OPEN = 3'd0;
  localparam logic [2:0] T_ROM  = 3'd1;
  localparam logic [2:0] T_RAMR = 3'd2;
  localparam logic [2:0] T_RAMW = 3'd3;
  localparam logic [2:0] T_NONE = 3'd4;

  // Configuration register indexes
  localparam logic [1:0] CFG_ROM_BANKS = 2'd0;
  localparam logic [1:0] CFG_RAM_BANKS = 2'd1;
  localparam logic [1:0] CFG_RAM_MASK  = 2'd2;
  localparam logic [1:0] CFG_RUMBLE    = 2'd3;

  // Sequencer states
  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_DECODE = 2'd1;
  localparam logic [1:0] S_MOD    = 2'd2;
  localparam logic [1:0] S_DONE   = 2'd3;

  // Bank register write windows, addr[14:12] of a write below 0x8000
  localparam logic [2:0] W_RAMEN0 = 3'd0;
  localparam logic [2:0] W_RAMEN1 = 3'd1;
  localparam logic [2:0] W_ROMLO  = 3'd2;
  localparam logic [2:0] W_ROMHI  = 3'd3;
  localparam logic [2:0] W_RAMBK0 = 3'd4;
  localparam logic [2:0] W_RAMBK1 = 3'd5;

  localparam logic [7:0]  RAM_EN_KEY      = 8'h0A;
  localparam logic [9:0]  ROM_BANKS_RST   = 10'd2;
  localparam logic [12:0] RAM_MASK_RST    = 13'h1FFF;
  localparam logic [3:0]  MOD_TOP_BIT     = 4'd8;

endpackage

@@ hw/rtl/cartridge_bank_mapper_unit.sv @@
// Cartridge bank mapper (MBC5-style): translates CPU bus transactions into ROM / save RAM
// addresses. Depends on cbm_pkg and cartridge_bank_mapper_unit_defines.svh.
// Reads and non-bank writes pass through DECODE and DONE to the output register; writes to
// ROM or RAM bank registers add MOD: two 9-step remainder passes on one subtract/compare unit.
// One transaction at a time, none taken until the last leaves DONE; a count write stalls in MOD.
// Reset is asynchronous: ROM bank 1, RAM bank 0, RAM disabled, registers to defaults.
`include "cartridge_bank_mapper_unit_defines.svh"

module cartridge_bank_mapper_unit #(
  parameter int unsigned MaxRomBanks = cbm_pkg::MaxRomBanksDef,
  parameter int unsigned MaxRamBanks = cbm_pkg::MaxRamBanksDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration port
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [12:0] cfg_wdata_i,
  // input transactions
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        kind_i,
  input  logic [15:0] addr_i,
  input  logic [7:0]  wdata_i,
  // result transactions
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  target_o,
  output logic [22:0] mem_address_o,
  output logic [7:0]  mem_wdata_o
);
  import cbm_pkg::*;

  localparam logic [9:0] RomSat = 10'(MaxRomBanks);
  localparam logic [4:0] RamSat = 5'(MaxRamBanks);

  // configuration registers
  logic [9:0]  rom_banks_q;
  logic [4:0]  ram_banks_q;
  logic [12:0] ram_mask_q;
  logic        rumble_q;

  // mapper state
  logic [7:0]  rom_lo_q, rom_lo_d;
  logic        rom_hi_q, rom_hi_d;
  logic [3:0]  ram_bank_q, ram_bank_d;
  logic        ram_en_q, ram_en_d;
  logic [8:0]  eff_rom_q, eff_rom_d;
  logic [3:0]  eff_ram_q, eff_ram_d;

  // sequencer and held transaction
  logic [1:0]  state_q, state_d;
  logic        kind_q;
  logic [15:0] addr_q;
  logic [7:0]  wdata_q;
  logic        pend_q, pend_d;

  // remainder unit
  logic        phase_q, phase_d;   // 0: ROM bank, 1: RAM bank
  logic [3:0]  bit_q, bit_d;
  logic [9:0]  rem_q, rem_d;

  // held result and output register
  logic [2:0]  res_tgt_q, res_tgt_d;
  logic [22:0] res_addr_q, res_addr_d;
  logic [7:0]  res_data_q, res_data_d;
  logic        out_valid_q, out_valid_d;
  logic [2:0]  target_q;
  logic [22:0] mem_address_q;
  logic [7:0]  mem_wdata_q;

  logic [9:0]  nrom;
  logic [4:0]  nram;
  logic [8:0]  dividend;
  logic [9:0]  divisor;
  logic [9:0]  shifted;
  logic [9:0]  rem_next;
  logic        cfg_count_wr;
  logic        in_ram_win;
  logic        ram_ok;
  logic        out_load;

  // Saturate the bank counts to what the cartridge can address.
  assign nrom = (rom_banks_q > RomSat) ? RomSat : rom_banks_q;
  assign nram = (ram_banks_q > RamSat) ? RamSat : ram_banks_q;

  assign cfg_count_wr = cfg_we_i && (cfg_idx_i == CFG_ROM_BANKS || cfg_idx_i == CFG_RAM_BANKS);
  assign in_ram_win   = (addr_q[15:13] == 3'b101);
  assign ram_ok       = (nram != 5'd0) && ram_en_q;
  assign in_ready_o   = (state_q == S_IDLE);

  // Shared restoring-remainder step: shift in one dividend bit, subtract if it fits.
  assign dividend = phase_q ? {5'd0, ram_bank_q} : {rom_hi_q, rom_lo_q};
  assign divisor  = phase_q ? {5'd0, nram} : nrom;
  assign shifted  = {rem_q[8:0], dividend[bit_q]};
  assign rem_next = (shifted >= divisor) ? (shifted - divisor) : shifted;

  assign out_load = (state_q == S_DONE) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d     = state_q;
    pend_d      = pend_q;
    phase_d     = phase_q;
    bit_d       = bit_q;
    rem_d       = rem_q;
    rom_lo_d    = rom_lo_q;
    rom_hi_d    = rom_hi_q;
    ram_bank_d  = ram_bank_q;
    ram_en_d    = ram_en_q;
    eff_rom_d   = eff_rom_q;
    eff_ram_d   = eff_ram_q;
    res_tgt_d   = res_tgt_q;
    res_addr_d  = res_addr_q;
    res_data_d  = res_data_q;
    out_valid_d = out_valid_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        // Work out the result from the banks as they stand, then apply writes.
        res_tgt_d  = T_OPEN;
        res_addr_d = '0;
        res_data_d = '0;
        pend_d     = 1'b1;
        state_d    = S_DONE;
        if (!kind_q) begin
          if (addr_q[15:14] == 2'b00) begin
            res_tgt_d  = T_ROM;
            res_addr_d = {7'd0, addr_q};
          end else if (addr_q[15:14] == 2'b01) begin
            res_tgt_d  = T_ROM;
            res_addr_d = {eff_rom_q, addr_q[13:0]};
          end else if (in_ram_win && ram_ok) begin
            res_tgt_d  = T_RAMR;
            res_addr_d = {6'd0, eff_ram_q, addr_q[12:0] & ram_mask_q};
          end
        end else begin
          res_tgt_d = T_NONE;
          if (!addr_q[15]) begin
            unique case (addr_q[14:12])
              W_RAMEN0, W_RAMEN1: ram_en_d = (wdata_q == RAM_EN_KEY);
              W_ROMLO: begin
                rom_lo_d = wdata_q;
                state_d  = S_MOD;
              end
              W_ROMHI: begin
                rom_hi_d = wdata_q[0];
                state_d  = S_MOD;
              end
              W_RAMBK0, W_RAMBK1: begin
                ram_bank_d = rumble_q ? {1'b0, wdata_q[2:0]} : wdata_q[3:0];
                state_d    = S_MOD;
              end
              default: ;
            endcase
          end else if (in_ram_win && ram_ok) begin
            res_tgt_d  = T_RAMW;
            res_addr_d = {6'd0, eff_ram_q, addr_q[12:0] & ram_mask_q};
            res_data_d = wdata_q;
          end
          // Restart the remainder unit from the top on every write; it runs only when a bank changes.
          phase_d = 1'b0;
          bit_d   = MOD_TOP_BIT;
          rem_d   = '0;
        end
      end
      S_MOD: begin
        rem_d = rem_next;
        bit_d = bit_q - 4'd1;
        if (bit_q == 4'd0) begin
          rem_d = '0;
          bit_d = MOD_TOP_BIT;
          if (!phase_q) begin
            eff_rom_d = (divisor == 10'd0) ? 9'd0 : rem_next[8:0];
            phase_d   = 1'b1;
          end else begin
            eff_ram_d = (divisor == 10'd0) ? 4'd0 : rem_next[3:0];
            phase_d   = 1'b0;
            state_d   = pend_q ? S_DONE : S_IDLE;
          end
        end
      end
      S_DONE: begin
        // Hold the result until the output register frees up.
        if (out_load) begin
          out_valid_d = 1'b1;
          pend_d      = 1'b0;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    // A bank count write recomputes both effective banks; write counts only while idle (not enforced here).
    if (cfg_count_wr) begin
      state_d = S_MOD;
      phase_d = 1'b0;
      bit_d   = MOD_TOP_BIT;
      rem_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pend_q      <= 1'b0;
      phase_q     <= 1'b0;
      bit_q       <= MOD_TOP_BIT;
      rem_q       <= '0;
      rom_banks_q <= ROM_BANKS_RST;
      ram_banks_q <= '0;
      ram_mask_q  <= RAM_MASK_RST;
      rumble_q    <= 1'b0;
      rom_lo_q    <= 8'd1;
      rom_hi_q    <= 1'b0;
      ram_bank_q  <= '0;
      ram_en_q    <= 1'b0;
      eff_rom_q   <= 9'd1;
      eff_ram_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pend_q      <= pend_d;
      phase_q     <= phase_d;
      bit_q       <= bit_d;
      rem_q       <= rem_d;
      rom_lo_q    <= rom_lo_d;
      rom_hi_q    <= rom_hi_d;
      ram_bank_q  <= ram_bank_d;
      ram_en_q    <= ram_en_d;
      eff_rom_q   <= eff_rom_d;
      eff_ram_q   <= eff_ram_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_ROM_BANKS: rom_banks_q <= cfg_wdata_i[9:0];
          CFG_RAM_BANKS: ram_banks_q <= cfg_wdata_i[4:0];
          CFG_RAM_MASK:  ram_mask_q  <= cfg_wdata_i;
          CFG_RUMBLE:    rumble_q    <= cfg_wdata_i[0];
          default: ;
        endcase
      end
    end
  end

  // Payload registers: captured transaction, held result, output stage.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      kind_q  <= kind_i;
      addr_q  <= addr_i;
      wdata_q <= wdata_i;
    end
    res_tgt_q  <= res_tgt_d;
    res_addr_q <= res_addr_d;
    res_data_q <= res_data_d;
    if (out_load) begin
      target_q      <= res_tgt_q;
      mem_address_q <= res_addr_q;
      mem_wdata_q   <= res_data_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign target_o      = target_q;
  assign mem_address_o = mem_address_q;
  assign mem_wdata_o   = mem_wdata_q;

  `CBM_ASSERT_NXT(a_accept_decodes, clk_i, rst_ni, in_valid_i && in_ready_o, state_q == S_DECODE)
  `CBM_ASSERT_IMP(a_busy_not_ready, clk_i, rst_ni, state_q != S_IDLE, !in_ready_o)
  `CBM_ASSERT_IMP(a_ram_bank_in_range, clk_i, rst_ni, state_q != S_MOD && nram != 5'd0, 5'(eff_ram_q) < nram)
  `CBM_ASSERT_IMP(a_rom_bank_in_range, clk_i, rst_ni, state_q != S_MOD && nrom != 10'd0, 10'(eff_rom_q) < nrom)
  `CBM_ASSERT_IMP(a_ram_write_has_ram, clk_i, rst_ni, out_load && res_tgt_q == T_RAMW, nram != 5'd0)

endmodule
